// ----- src/tcc_pkg.sv -----
// Package for the contiguous transfer coalescer.
// Holds field widths, payload structs and status structs; no dependencies.
`timescale 1ns / 1ps
package tcc_pkg;

  localparam int ADDRESS_BITS = 48;
  localparam int TAG_BITS     = 8;
  localparam int SECTOR_SHIFT = 9;
  localparam int SECTOR_BITS  = 40;
  localparam int SEG_BITS     = 17;
  localparam int BYTES_BITS   = 21;
  localparam int OFFSET_BITS  = SECTOR_BITS + SECTOR_SHIFT;

  localparam logic [BYTES_BITS-1:0] MAX_MERGE_RESET = BYTES_BITS'(131072);

  localparam int PADDR_BITS = 3;
  localparam logic REG_MAX_MERGE = 1'b0;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int LEVEL_BITS = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic                    is_write;
    logic [ADDRESS_BITS-1:0] buffer_address;
    logic [SECTOR_BITS-1:0]  start_sector;
    logic [SEG_BITS-1:0]     segment_bytes;
    logic [TAG_BITS-1:0]     request_tag;
    logic                    last_segment;
  } in_t;

  typedef struct packed {
    logic                    out_write;
    logic [ADDRESS_BITS-1:0] out_address;
    logic [OFFSET_BITS-1:0]  out_offset;
    logic [BYTES_BITS-1:0]   transfer_bytes;
    logic [TAG_BITS-1:0]     out_tag;
    logic                    request_done;
    logic                    run_last;
  } out_t;

  typedef struct packed {
    logic push0;
    logic push1;
    out_t res0;
    out_t res1;
  } push_t;

  typedef struct packed {
    logic advance;
    logic closing;
    logic pend_valid;
  } merge_stat_t;

endpackage

// ----- src/tcc_cfg.sv -----
// Configuration register block of the coalescer: APB-style port holding
// max_merge_bytes. Depends on tcc_pkg.
`timescale 1ns / 1ps
module tcc_cfg
  import tcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output logic [BYTES_BITS-1:0] max_merge
);

  logic [BYTES_BITS-1:0] max_merge_r;
  logic [BYTES_BITS-1:0] max_merge_nxt;
  logic                  hit;

  assign hit = (paddr[2] == REG_MAX_MERGE) && (paddr[1:0] == 2'b00);

  always_comb begin
    max_merge_nxt = max_merge_r;
    if (psel && penable && pwrite && hit) begin
      max_merge_nxt = pwdata[BYTES_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_merge_r <= MAX_MERGE_RESET;
    end else begin
      max_merge_r <= max_merge_nxt;
    end
  end

  assign pready    = 1'b1;
  assign prdata    = hit ? 32'(max_merge_r) : 32'd0;
  assign max_merge = max_merge_r;

endmodule

// ----- src/tcc_merge.sv -----
// Input register, pending transfer and contiguity/merge decision.
// Produces up to two results per segment for the output queue. Depends on tcc_pkg.
`timescale 1ns / 1ps
module tcc_merge
  import tcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [BYTES_BITS-1:0] max_merge,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  input  logic [LEVEL_BITS-1:0] fifo_level,
  output push_t                 push,
  output merge_stat_t           stat
);

  logic                    s0_valid_r, s0_valid_nxt;
  in_t                     s0_data_r;
  logic                    pend_valid_r, pend_valid_nxt;
  logic                    pend_write_r, pend_write_nxt;
  logic [ADDRESS_BITS-1:0] pend_addr_r, pend_addr_nxt;
  logic [OFFSET_BITS-1:0]  pend_off_r, pend_off_nxt;
  logic [BYTES_BITS-1:0]   pend_bytes_r, pend_bytes_nxt;
  logic [TAG_BITS-1:0]     pend_tag_r, pend_tag_nxt;

  logic                    adv;
  logic                    accept;
  logic [BYTES_BITS-1:0]   seg_len;
  logic [OFFSET_BITS-1:0]  seg_off;
  logic [ADDRESS_BITS-1:0] addr_end;
  logic [OFFSET_BITS:0]    off_end;
  logic [BYTES_BITS:0]     len_sum;
  logic                    merge;
  logic                    flush;
  out_t                    old_res;
  out_t                    close_res;

  assign adv      = s0_valid_r && (fifo_level <= LEVEL_BITS'(FIFO_DEPTH - 2));
  assign in_stall = s0_valid_r && !adv;
  assign accept   = in_valid && !in_stall;

  assign seg_len  = BYTES_BITS'({s0_data_r.segment_bytes[SEG_BITS-1:SECTOR_SHIFT],
                                 SECTOR_SHIFT'(0)});
  assign seg_off  = {s0_data_r.start_sector, SECTOR_SHIFT'(0)};
  assign addr_end = pend_addr_r + ADDRESS_BITS'(pend_bytes_r);
  assign off_end  = {1'b0, pend_off_r} + (OFFSET_BITS+1)'(pend_bytes_r);
  assign len_sum  = {1'b0, pend_bytes_r} + {1'b0, seg_len};

  assign merge = pend_valid_r
              && (s0_data_r.is_write == pend_write_r)
              && (s0_data_r.request_tag == pend_tag_r)
              && (addr_end == s0_data_r.buffer_address)
              && (off_end == {1'b0, seg_off})
              && (len_sum <= {1'b0, max_merge});
  assign flush = pend_valid_r && !merge;

  always_comb begin
    s0_valid_nxt   = s0_valid_r;
    pend_valid_nxt = pend_valid_r;
    pend_write_nxt = pend_write_r;
    pend_addr_nxt  = pend_addr_r;
    pend_off_nxt   = pend_off_r;
    pend_bytes_nxt = pend_bytes_r;
    pend_tag_nxt   = pend_tag_r;
    if (adv) begin
      s0_valid_nxt = 1'b0;
      if (merge) begin
        pend_bytes_nxt = len_sum[BYTES_BITS-1:0];
      end else begin
        pend_write_nxt = s0_data_r.is_write;
        pend_addr_nxt  = s0_data_r.buffer_address;
        pend_off_nxt   = seg_off;
        pend_bytes_nxt = seg_len;
        pend_tag_nxt   = s0_data_r.request_tag;
      end
      pend_valid_nxt = !s0_data_r.last_segment;
    end
    if (accept) begin
      s0_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    old_res.out_write      = pend_write_r;
    old_res.out_address    = pend_addr_r;
    old_res.out_offset     = pend_off_r;
    old_res.transfer_bytes = pend_bytes_r;
    old_res.out_tag        = pend_tag_r;
    old_res.request_done   = 1'b0;
    old_res.run_last       = !s0_data_r.last_segment;

    close_res.out_write      = pend_write_nxt;
    close_res.out_address    = pend_addr_nxt;
    close_res.out_offset     = pend_off_nxt;
    close_res.transfer_bytes = pend_bytes_nxt;
    close_res.out_tag        = pend_tag_nxt;
    close_res.request_done   = 1'b1;
    close_res.run_last       = 1'b1;

    push.push0 = adv && (flush || s0_data_r.last_segment);
    push.push1 = adv && flush && s0_data_r.last_segment;
    push.res0  = flush ? old_res : close_res;
    push.res1  = close_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r   <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      s0_valid_r   <= s0_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_data_r <= in_data;
    end
    pend_write_r <= pend_write_nxt;
    pend_addr_r  <= pend_addr_nxt;
    pend_off_r   <= pend_off_nxt;
    pend_bytes_r <= pend_bytes_nxt;
    pend_tag_r   <= pend_tag_nxt;
  end

  assign stat.advance    = adv;
  assign stat.closing    = s0_data_r.last_segment;
  assign stat.pend_valid = pend_valid_r;

endmodule

// ----- src/tcc_fifo.sv -----
// Result queue of the coalescer: takes up to two transfers per cycle and
// hands one per cycle to the output channel while out_stall is low. Depends on tcc_pkg.
`timescale 1ns / 1ps
module tcc_fifo
  import tcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  push_t                 push,
  output logic [LEVEL_BITS-1:0] level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data
);

  out_t                  mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0]   head_r, head_nxt;
  logic [PTR_BITS-1:0]   tail_r, tail_nxt;
  logic [PTR_BITS-1:0]   tail_p1;
  logic [LEVEL_BITS-1:0] level_r, level_nxt;
  logic                  pop;

  assign out_valid = (level_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = mem[head_r];
  assign tail_p1   = tail_r + PTR_BITS'(1);

  always_comb begin
    head_nxt  = pop ? head_r + PTR_BITS'(1) : head_r;
    tail_nxt  = tail_r + PTR_BITS'(push.push0) + PTR_BITS'(push.push1);
    level_nxt = level_r + LEVEL_BITS'(push.push0) + LEVEL_BITS'(push.push1)
              - LEVEL_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      level_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem[tail_r] <= push.res0;
    end
    if (push.push1) begin
      mem[tail_p1] <= push.res1;
    end
  end

  assign level = level_r;

endmodule

// ----- src/contiguous_transfer_coalescer.sv -----
// Top level of the contiguous transfer coalescer: config block, merge stage
// and result queue. Depends on tcc_pkg, tcc_cfg, tcc_merge, tcc_fifo.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall   in_t   (one segment)
//   out_     output     out_valid/out_stall out_t  (one transfer)
//   cfg      input      APB psel/penable    max_merge_bytes at 0x0
//
// A segment is registered, then compared and merged once the result queue has room; one
// segment per cycle is taken while the four-entry result queue holds at most two.
// Results pass from the input register through the result queue to out_valid.
// A segment that closes a request and flushes an older transfer puts two
// results in the queue; the output drains one per cycle while out_stall is low.
// Reset is synchronous: nothing pending, queue empty, cap back to 131072.
// out_stall backs up the queue, then the input register, then in_stall.
`timescale 1ns / 1ps
module contiguous_transfer_coalescer
  import tcc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [BYTES_BITS-1:0] max_merge;
  logic [LEVEL_BITS-1:0] fifo_level;
  push_t                 push;
  merge_stat_t           stat;

  tcc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_merge (max_merge)
  );

  tcc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_merge  (max_merge),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .fifo_level (fifo_level),
    .push       (push),
    .stat       (stat)
  );

  tcc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .level     (fifo_level),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_level <= LEVEL_BITS'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.advance && stat.closing) |=> !stat.pend_valid)
    else $error("pending transfer kept after request closed");

  a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> (push.push0 && push.res1.run_last && !push.res0.run_last))
    else $error("second result without a flushed first");

  a_level_grows_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    (!push.push0) |=> (fifo_level <= $past(fifo_level)))
    else $error("queue level rose without a push");

endmodule

// ----- tb/tb_contiguous_transfer_coalescer.sv -----
// Testbench for contiguous_transfer_coalescer: directed and random segment traffic,
// checked against an in-bench merge predictor with random idling on both channels.
// Depends on tcc_pkg and the contiguous_transfer_coalescer RTL.
`timescale 1ns / 1ps
module tb_contiguous_transfer_coalescer;
  import tcc_pkg::*;

  localparam logic [PADDR_BITS-1:0] CAP_ADDR   = PADDR_BITS'(4 * REG_MAX_MERGE);
  localparam logic [PADDR_BITS-1:0] SPARE_ADDR = PADDR_BITS'(4);
  localparam logic CFG_WRITE = 1'b1;
  localparam logic CFG_READ  = 1'b0;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [ADDRESS_BITS-1:0] ADDR_TOP   = {ADDRESS_BITS{1'b1}};
  localparam logic [SECTOR_BITS-1:0]  SECTOR_TOP = {SECTOR_BITS{1'b1}};

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  // predictor state: the open (not yet emitted) transfer and the merge cap
  logic                    open_valid = 1'b0;
  logic                    open_write = 1'b0;
  logic [ADDRESS_BITS-1:0] open_addr  = '0;
  logic [OFFSET_BITS-1:0]  open_off   = '0;
  logic [BYTES_BITS-1:0]   open_bytes = '0;
  logic [TAG_BITS-1:0]     open_tag   = '0;
  logic [BYTES_BITS-1:0]   merge_cap  = MAX_MERGE_RESET;

  out_t transfers_due[$];
  int   fail_count  = 0;
  int   hold_cycles = 0;
  logic in_idle_on  = 1'b0;
  logic out_idle_on = 1'b0;

  contiguous_transfer_coalescer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic out_t open_transfer(input logic done, input logic run_end);
    out_t t;
    t.out_write      = open_write;
    t.out_address    = open_addr;
    t.out_offset     = open_off;
    t.transfer_bytes = open_bytes;
    t.out_tag        = open_tag;
    t.request_done   = done;
    t.run_last       = run_end;
    return t;
  endfunction

  function automatic void predict_transfers(input in_t seg);
    logic [BYTES_BITS-1:0]  len;
    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS:0]   open_end;
    logic [BYTES_BITS:0]    merged;
    logic                   merges;
    len = BYTES_BITS'({seg.segment_bytes[SEG_BITS-1:SECTOR_SHIFT], {SECTOR_SHIFT{1'b0}}});
    off = {seg.start_sector, {SECTOR_SHIFT{1'b0}}};
    open_end = {1'b0, open_off} + (OFFSET_BITS + 1)'(open_bytes);
    merged = {1'b0, open_bytes} + {1'b0, len};
    merges = open_valid && seg.is_write == open_write && seg.request_tag == open_tag
          && open_addr + ADDRESS_BITS'(open_bytes) == seg.buffer_address
          && open_end == {1'b0, off} && merged <= {1'b0, merge_cap};
    if (merges) begin
      open_bytes = merged[BYTES_BITS-1:0];
    end else begin
      if (open_valid) transfers_due.push_back(open_transfer(1'b0, !seg.last_segment));
      open_valid = 1'b1;
      open_write = seg.is_write;
      open_addr  = seg.buffer_address;
      open_off   = off;
      open_bytes = len;
      open_tag   = seg.request_tag;
    end
    if (seg.last_segment) begin
      transfers_due.push_back(open_transfer(1'b1, 1'b1));
      open_valid = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
    fail_count++;
  endtask

  always @(posedge clk) begin : check_transfers
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (transfers_due.size() == 0) begin
        $display("%0t: unexpected transfer expected none actual %p", $time, out_data);
        fail_count++;
      end else begin
        want = transfers_due.pop_front();
        if (out_data.out_write !== want.out_write)
          report_mismatch("out_write", want.out_write, out_data.out_write);
        if (out_data.out_address !== want.out_address)
          report_mismatch("out_address", want.out_address, out_data.out_address);
        if (out_data.out_offset !== want.out_offset)
          report_mismatch("out_offset", want.out_offset, out_data.out_offset);
        if (out_data.transfer_bytes !== want.transfer_bytes)
          report_mismatch("transfer_bytes", want.transfer_bytes, out_data.transfer_bytes);
        if (out_data.out_tag !== want.out_tag)
          report_mismatch("out_tag", want.out_tag, out_data.out_tag);
        if (out_data.request_done !== want.request_done)
          report_mismatch("request_done", want.request_done, out_data.request_done);
        if (out_data.run_last !== want.run_last)
          report_mismatch("run_last", want.run_last, out_data.run_last);
      end
    end
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (hold_cycles == 0 && out_idle_on && $urandom_range(0, 7) == 0)
      hold_cycles = $urandom_range(1, 19);
    out_stall <= (hold_cycles != 0);
    if (hold_cycles != 0) hold_cycles--;
  end

  function automatic in_t make_seg(input logic wr, input logic [ADDRESS_BITS-1:0] addr,
                                   input logic [SECTOR_BITS-1:0] sector,
                                   input logic [SEG_BITS-1:0] nbytes,
                                   input logic [TAG_BITS-1:0] tag, input logic closes);
    in_t s;
    s.is_write       = wr;
    s.buffer_address = addr;
    s.start_sector   = sector;
    s.segment_bytes  = nbytes;
    s.request_tag    = tag;
    s.last_segment   = closes;
    return s;
  endfunction

  task automatic send_segment(input in_t seg);
    @(negedge clk);
    if (in_idle_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= seg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_transfers(seg);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (transfers_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [PADDR_BITS-1:0] addr,
                            input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr && addr == CAP_ADDR)
      merge_cap = data[BYTES_BITS-1:0];
    else if (!wr && prdata !== 32'(merge_cap))
      report_mismatch("max_merge_bytes", 64'(merge_cap), 64'(prdata));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_cap();
    cfg_access(CFG_READ, CAP_ADDR, '0);
    send_segment(make_seg(1'b1, 48'h1000, 40'd8, 17'd65536, 8'd1, 1'b0));
    send_segment(make_seg(1'b1, 48'h11000, 40'd136, 17'd65536, 8'd1, 1'b0));
    send_segment(make_seg(1'b1, 48'h21000, 40'd264, 17'd512, 8'd1, 1'b1));
  endtask

  task automatic test_field_extremes();
    send_segment(make_seg(1'b1, ADDR_TOP, SECTOR_TOP, {SEG_BITS{1'b1}}, 8'hFF, 1'b1));
    send_segment(make_seg(1'b0, '0, '0, '0, '0, 1'b1));
  endtask

  task automatic test_direction_and_tag();
    send_segment(make_seg(1'b0, 48'h2000, 40'd100, 17'd4096, 8'd7, 1'b0));
    send_segment(make_seg(1'b1, 48'h3000, 40'd108, 17'd1024, 8'd7, 1'b0));
    send_segment(make_seg(1'b1, 48'h3400, 40'd110, 17'd512, 8'd9, 1'b0));
    send_segment(make_seg(1'b1, 48'h3600, 40'd111, 17'd512, 8'd9, 1'b1));
    send_segment(make_seg(1'b0, 48'h5000, 40'd200, 17'd512, 8'd3, 1'b0));
    send_segment(make_seg(1'b0, 48'h5200, 40'd202, 17'd512, 8'd3, 1'b1));
  endtask

  task automatic test_address_wrap();
    send_segment(make_seg(1'b0, ADDR_TOP - 1023, 40'd50, 17'd1024, 8'd4, 1'b0));
    send_segment(make_seg(1'b0, '0, 40'd52, 17'd512, 8'd4, 1'b1));
    send_segment(make_seg(1'b1, 48'h100, SECTOR_TOP, 17'd512, 8'd5, 1'b0));
    send_segment(make_seg(1'b1, 48'h300, '0, 17'd512, 8'd5, 1'b1));
  endtask

  task automatic test_zero_length();
    send_segment(make_seg(1'b0, 48'h8000, 40'd64, 17'd300, 8'd6, 1'b0));
    send_segment(make_seg(1'b0, 48'h8000, 40'd64, 17'd511, 8'd6, 1'b0));
    send_segment(make_seg(1'b0, 48'h8000, 40'd64, 17'd2048, 8'd6, 1'b1));
    send_segment(make_seg(1'b0, 48'h9000, 40'd1, 17'd100, 8'd6, 1'b1));
  endtask

  task automatic test_cap_limits();
    settle();
    cfg_access(CFG_WRITE, CAP_ADDR, 32'd512);
    cfg_access(CFG_READ, CAP_ADDR, '0);
    send_segment(make_seg(1'b1, 48'h10000, 40'd1000, 17'd65536, 8'd2, 1'b0));
    send_segment(make_seg(1'b1, 48'h20000, 40'd1128, 17'd512, 8'd2, 1'b1));
    settle();
    cfg_access(CFG_WRITE, SPARE_ADDR, 32'd0);
    cfg_access(CFG_WRITE, CAP_ADDR, 32'd1048576);
    cfg_access(CFG_READ, CAP_ADDR, '0);
    send_segment(make_seg(1'b0, 48'h40000, 40'd0, 17'd130560, 8'd8, 1'b0));
    send_segment(make_seg(1'b0, 48'h5FE00, 40'd255, 17'd130560, 8'd8, 1'b1));
  endtask

  function automatic logic [SEG_BITS-1:0] pick_length();
    case ($urandom_range(0, 9))
      0: return SEG_BITS'($urandom);
      1: return ($urandom_range(0, 1) == 0) ? SEG_BITS'(65536) : SEG_BITS'(130560);
      2: return SEG_BITS'($urandom_range(0, 511));
      default: return SEG_BITS'(512 * $urandom_range(1, 16));
    endcase
  endfunction

  task automatic run_requests(input int budget);
    int                      sent;
    int                      parts;
    logic [ADDRESS_BITS-1:0] addr;
    logic [SECTOR_BITS-1:0]  sector;
    logic [SEG_BITS-1:0]     nbytes;
    logic [TAG_BITS-1:0]     tag;
    logic                    wr;
    logic                    closes;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        send_segment(make_seg(1'($urandom), ADDRESS_BITS'({$urandom, $urandom}),
                              SECTOR_BITS'({$urandom, $urandom}), SEG_BITS'($urandom),
                              TAG_BITS'($urandom), 1'($urandom)));
        sent++;
      end else begin
        wr  = 1'($urandom);
        tag = ($urandom_range(0, 1) == 0) ? TAG_BITS'($urandom_range(0, 3))
                                           : TAG_BITS'($urandom);
        addr = ($urandom_range(0, 7) == 0)
             ? ADDR_TOP - ADDRESS_BITS'(512 * $urandom_range(0, 7) + 511)
             : ADDRESS_BITS'({$urandom, $urandom});
        sector = ($urandom_range(0, 7) == 0)
               ? SECTOR_TOP - SECTOR_BITS'($urandom_range(0, 7))
               : SECTOR_BITS'({$urandom, $urandom});
        parts = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        for (int j = 0; j < parts && sent < budget; j++) begin
          nbytes = pick_length();
          if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 3))
              0: wr = ~wr;
              1: addr = addr + 512;
              2: sector = sector + 1;
              default: tag = tag + 1;
            endcase
          end
          closes = (j == parts - 1) && $urandom_range(0, 9) != 0;
          send_segment(make_seg(wr, addr, sector, nbytes, tag, closes));
          sent++;
          addr   = addr + ADDRESS_BITS'({nbytes[SEG_BITS-1:SECTOR_SHIFT], {SECTOR_SHIFT{1'b0}}});
          sector = sector + SECTOR_BITS'(nbytes[SEG_BITS-1:SECTOR_SHIFT]);
        end
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [31:0] cap_value;
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase)
        0: cap_value = 32'd512;
        1: cap_value = 32'd1048576;
        2: cap_value = 32'(MAX_MERGE_RESET);
        default: cap_value = $urandom_range(512, 1048576);
      endcase
      if (phase == 3) cfg_access(CFG_WRITE, SPARE_ADDR, $urandom);
      cfg_access(CFG_WRITE, CAP_ADDR, cap_value);
      cfg_access(CFG_READ, CAP_ADDR, '0);
      in_idle_on  = phase != 7 && $urandom_range(0, 3) != 0;
      out_idle_on = phase != 7 && $urandom_range(0, 3) != 0;
      run_requests(205);
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    test_reset_cap();
    test_field_extremes();
    test_direction_and_tag();
    test_address_wrap();
    test_zero_length();
    test_cap_limits();
    test_random_traffic();
    settle();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
